@@ rtl/ovn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared types, codes and constants of the octave value noise unit.
// ----------------------------------------------------------------------------
package ovn_pkg;

   localparam int DEF_TABLE_DEPTH   = 256;
   localparam int DEF_MAX_OCTAVES   = 8;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int NOISE_W    = 16;
   localparam int AMP_W      = 16;
   localparam int PERS_W     = 17;
   localparam int FREQ_W     = 24;
   localparam int COUNT_W    = 4;
   localparam int OCT_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // lattice cell is 32 bits, reduced one nibble per stage
   localparam int RED_STAGES  = 8;
   localparam int FADE_STAGES = 5;
   localparam int DIV_STAGES  = 8;

   // quintic fade 6t^5 - 15t^4 + 10t^3
   localparam int FADE_C5 = 6;
   localparam int FADE_C4 = 15;
   localparam int FADE_C3 = 10;

   localparam logic [COUNT_W-1:0]    RST_OCTAVE_COUNT   = 4'd1;
   localparam logic [PERS_W-1:0]     RST_PERSISTENCE    = 17'd32768;
   localparam logic [FREQ_W-1:0]     RST_BASE_FREQUENCY = 24'd65536;
   localparam logic [AMP_W-1:0]      RST_BASE_AMPLITUDE = 16'd256;
   localparam logic [COORD_W-1:0]    RST_PHASE_OFFSET   = 32'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OCTAVE_COUNT   = 3'd0,
      CSR_PERSISTENCE    = 3'd1,
      CSR_BASE_FREQUENCY = 3'd2,
      CSR_BASE_AMPLITUDE = 3'd3,
      CSR_PHASE_OFFSET   = 3'd4
   } csr_reg_type;

   typedef enum logic {
      ACTION_LOAD     = 1'b0,
      ACTION_EVALUATE = 1'b1
   } action_type;

   typedef struct packed {
      logic                      busy;
      logic [OCT_W-1:0]          octaves;
      logic [FREQ_W-1:0]         freq;
      logic signed [COORD_W-1:0] offset;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic evaluate;
   } meta_type;

endpackage

@@ rtl/ovn_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_lane
// One octave: lattice index reduction, quintic fade, table copy and blend.
// ----------------------------------------------------------------------------
module ovn_lane #(
   parameter int TABLE_DEPTH   = ovn_pkg::DEF_TABLE_DEPTH,
   parameter int FRACTION_BITS = ovn_pkg::DEF_FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             advance,
   input  logic [63:0]                      pos,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   input  logic [ovn_pkg::NOISE_W-1:0]      wr_data,
   output logic [ovn_pkg::NOISE_W-1:0]      value
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int F     = FRACTION_BITS;
   localparam int S_W   = F + 1;
   localparam int P_W   = F + 5;
   localparam int BL_W  = ovn_pkg::NOISE_W + F + 1;
   localparam int RED   = ovn_pkg::RED_STAGES;
   localparam int DLY   = ovn_pkg::RED_STAGES - ovn_pkg::FADE_STAGES;
   localparam logic [IDX_W:0]   DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [S_W-1:0]   ONE_C   = {1'b1, {F{1'b0}}};

   function automatic logic [IDX_W-1:0] reduce_nibble(input logic [IDX_W-1:0] r,
                                                      input logic [3:0] nib);
      logic [IDX_W:0]   acc;
      logic [IDX_W-1:0] cur;
      cur = r;
      for (int k = 3; k >= 0; k--) begin
         acc = {cur, nib[k]};
         if (acc >= DEPTH_C) begin
            acc = acc - DEPTH_C;
         end
         cur = acc[IDX_W-1:0];
      end
      return cur;
   endfunction

   function automatic logic [F-1:0] mul_frac(input logic [F-1:0] a, input logic [F-1:0] b);
      logic [2*F-1:0] p;
      p = a * b;
      return p[2*F-1:F];
   endfunction

   // cell modulo depth, most significant nibble first
   logic [IDX_W-1:0] rem_ff  [RED];
   logic [31:0]      cell_ff [RED];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= reduce_nibble('0, pos[63:60]);
         cell_ff[0] <= {pos[59:32], 4'b0};
         for (int j = 1; j < RED; j++) begin
            rem_ff[j]  <= reduce_nibble(rem_ff[j-1], cell_ff[j-1][31:28]);
            cell_ff[j] <= {cell_ff[j-1][27:0], 4'b0};
         end
      end
   end

   // fade powers, one product per stage
   logic [F-1:0]   ta_ff, tb_ff, tc_ff;
   logic [F-1:0]   t2_ff, t3_ff, t3c_ff, t3d_ff, t4_ff, t4d_ff, t5_ff;
   logic [S_W-1:0] s_ff;
   logic [S_W-1:0] s_dly_ff [DLY];
   logic [S_W-1:0] s_in;
   logic [P_W-1:0] up_sum, dn_sum, diff;

   always_comb begin
      up_sum = P_W'(t5_ff) * P_W'(ovn_pkg::FADE_C5) + P_W'(t3d_ff) * P_W'(ovn_pkg::FADE_C3);
      dn_sum = P_W'(t4d_ff) * P_W'(ovn_pkg::FADE_C4);
      diff   = up_sum - dn_sum;
      if (dn_sum >= up_sum) begin
         s_in = '0;
      end else if (diff > P_W'(ONE_C)) begin
         s_in = ONE_C;
      end else begin
         s_in = diff[S_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ta_ff  <= pos[31 -: F];
         t2_ff  <= mul_frac(pos[31 -: F], pos[31 -: F]);
         tb_ff  <= ta_ff;
         t3_ff  <= mul_frac(t2_ff, ta_ff);
         tc_ff  <= tb_ff;
         t3c_ff <= t3_ff;
         t4_ff  <= mul_frac(t3_ff, tb_ff);
         t3d_ff <= t3c_ff;
         t4d_ff <= t4_ff;
         t5_ff  <= mul_frac(t4_ff, tc_ff);
         s_ff   <= s_in;
         s_dly_ff[0] <= s_ff;
         for (int j = 1; j < DLY; j++) begin
            s_dly_ff[j] <= s_dly_ff[j-1];
         end
      end
   end

   // private copy of the lattice, two read ports
   logic [ovn_pkg::NOISE_W-1:0] lattice_mem [TABLE_DEPTH];
   logic [ovn_pkg::NOISE_W-1:0] a_ff, b_ff;
   logic [S_W-1:0]              s_rd_ff;
   logic [IDX_W-1:0]            lo_addr, hi_addr;

   assign lo_addr = rem_ff[RED-1];
   assign hi_addr = (lo_addr == LAST_C) ? '0 : lo_addr + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lattice_mem[wr_addr] <= wr_data;
      end
      if (advance) begin
         a_ff    <= lattice_mem[lo_addr];
         b_ff    <= lattice_mem[hi_addr];
         s_rd_ff <= s_dly_ff[DLY-1];
      end
   end

   logic [BL_W-1:0]             mix;
   logic [ovn_pkg::NOISE_W-1:0] value_ff;

   assign mix = BL_W'(a_ff) * BL_W'(ONE_C - s_rd_ff) + BL_W'(b_ff) * BL_W'(s_rd_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= mix[F +: ovn_pkg::NOISE_W];
      end
   end

   assign value = value_ff;

endmodule

@@ rtl/ovn_weights.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_weights
// Control registers, octave amplitude chain and total weight.
// ----------------------------------------------------------------------------
module ovn_weights #(
   parameter int MAX_OCTAVES = ovn_pkg::DEF_MAX_OCTAVES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [ovn_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ovn_pkg::CSR_DATA_W-1:0]          csr_wdata,
   output ovn_pkg::cfg_type                        cfg,
   output logic [ovn_pkg::AMP_W-1:0]               amp [MAX_OCTAVES],
   output logic [ovn_pkg::AMP_W+$clog2(MAX_OCTAVES+1)-1:0] weight
);

   localparam int WGT_W  = ovn_pkg::AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int SETTLE = 2 * MAX_OCTAVES + 2;
   localparam int SET_W  = $clog2(SETTLE + 1);
   localparam int OCT_W  = ovn_pkg::OCT_W;

   logic [ovn_pkg::COUNT_W-1:0] count_ff;
   logic [ovn_pkg::PERS_W-1:0]  pers_ff;
   logic [ovn_pkg::FREQ_W-1:0]  freq_ff;
   logic [ovn_pkg::AMP_W-1:0]   bamp_ff;
   logic [ovn_pkg::COORD_W-1:0] offset_ff;
   logic [SET_W-1:0]            settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= ovn_pkg::RST_OCTAVE_COUNT;
         pers_ff   <= ovn_pkg::RST_PERSISTENCE;
         freq_ff   <= ovn_pkg::RST_BASE_FREQUENCY;
         bamp_ff   <= ovn_pkg::RST_BASE_AMPLITUDE;
         offset_ff <= ovn_pkg::RST_PHASE_OFFSET;
         settle_ff <= SET_W'(SETTLE);
      end else if (csr_write) begin
         unique case (ovn_pkg::csr_reg_type'(csr_index))
            ovn_pkg::CSR_OCTAVE_COUNT:   count_ff  <= csr_wdata[ovn_pkg::COUNT_W-1:0];
            ovn_pkg::CSR_PERSISTENCE:    pers_ff   <= csr_wdata[ovn_pkg::PERS_W-1:0];
            ovn_pkg::CSR_BASE_FREQUENCY: freq_ff   <= csr_wdata[ovn_pkg::FREQ_W-1:0];
            ovn_pkg::CSR_BASE_AMPLITUDE: bamp_ff   <= csr_wdata[ovn_pkg::AMP_W-1:0];
            ovn_pkg::CSR_PHASE_OFFSET:   offset_ff <= csr_wdata[ovn_pkg::COORD_W-1:0];
            default: ;
         endcase
         settle_ff <= SET_W'(SETTLE);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   // derived values ripple down registered chains after every write
   logic [OCT_W-1:0]          octaves_ff, octaves_in;
   logic [ovn_pkg::AMP_W-1:0] amp_ff  [MAX_OCTAVES];
   logic [ovn_pkg::AMP_W-1:0] amp_in  [MAX_OCTAVES];
   logic [WGT_W-1:0]          wsum_ff [MAX_OCTAVES];
   logic [WGT_W-1:0]          weight_ff, weight_in;
   logic [ovn_pkg::AMP_W+ovn_pkg::PERS_W-1:0] grow;

   always_comb begin
      if (count_ff == '0) begin
         octaves_in = OCT_W'(1);
      end else if (OCT_W'(count_ff) > OCT_W'(MAX_OCTAVES)) begin
         octaves_in = OCT_W'(MAX_OCTAVES);
      end else begin
         octaves_in = OCT_W'(count_ff);
      end
   end

   always_comb begin
      grow = '0;
      amp_in[0] = bamp_ff;
      for (int i = 1; i < MAX_OCTAVES; i++) begin
         grow = amp_ff[i-1] * pers_ff;
         if (grow[ovn_pkg::AMP_W+ovn_pkg::PERS_W-1:32] != '0) begin
            amp_in[i] = '1;
         end else begin
            amp_in[i] = grow[31:16];
         end
      end
   end

   always_comb begin
      weight_in = wsum_ff[0];
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         if (OCT_W'(i + 1) == octaves_ff) begin
            weight_in = wsum_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      octaves_ff <= octaves_in;
      weight_ff  <= weight_in;
      wsum_ff[0] <= WGT_W'(amp_ff[0]);
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         amp_ff[i] <= amp_in[i];
      end
      for (int i = 1; i < MAX_OCTAVES; i++) begin
         wsum_ff[i] <= wsum_ff[i-1] + WGT_W'(amp_ff[i]);
      end
   end

   assign cfg.busy    = (settle_ff != '0);
   assign cfg.octaves = octaves_ff;
   assign cfg.freq    = freq_ff;
   assign cfg.offset  = $signed(offset_ff);
   assign amp         = amp_ff;
   assign weight      = weight_ff;

endmodule

@@ rtl/ovn_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_divider
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module ovn_divider #(
   parameter int TOT_W = 36,
   parameter int WGT_W = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [TOT_W-1:0]            total,
   input  logic [WGT_W-1:0]            weight,
   output logic [ovn_pkg::NOISE_W-1:0] quotient
);

   localparam int Q_W      = ovn_pkg::NOISE_W;
   localparam int STAGES   = ovn_pkg::DIV_STAGES;
   localparam int BITS_PER = ovn_pkg::NOISE_W / ovn_pkg::DIV_STAGES;
   localparam int DIV_W    = WGT_W + ovn_pkg::NOISE_W;

   logic [DIV_W-1:0] rem_ff  [STAGES];
   logic [WGT_W-1:0] div_ff  [STAGES];
   logic [Q_W-1:0]   quo_ff  [STAGES];
   logic             zero_ff [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic [DIV_W-1:0] rem_src, rem_in;
      logic [WGT_W-1:0] div_src;
      logic [Q_W-1:0]   quo_src, quo_in;
      logic             zero_src;

      if (j == 0) begin : g_first
         assign rem_src  = DIV_W'(total);
         assign div_src  = weight;
         assign quo_src  = '0;
         assign zero_src = (weight == '0);
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign div_src  = div_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign zero_src = zero_ff[j-1];
      end

      always_comb begin
         logic [DIV_W-1:0] trial;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int b = 0; b < BITS_PER; b++) begin
            trial = DIV_W'(div_src) << (Q_W - 1 - (j * BITS_PER + b));
            if (rem_in >= trial) begin
               rem_in = rem_in - trial;
               quo_in[Q_W - 1 - (j * BITS_PER + b)] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in;
            div_ff[j]  <= div_src;
            quo_ff[j]  <= quo_in;
            zero_ff[j] <= zero_src;
         end
      end
   end

   // no weight at all gives zero noise
   assign quotient = zero_ff[STAGES-1] ? '0 : quo_ff[STAGES-1];

`ifndef SYNTHESIS
   a_divisor_captured: assert property (@(posedge clock) disable iff (reset)
      advance |=> (div_ff[0] === $past(weight)))
      else $error("divisor not captured on advance");
`endif

endmodule

@@ rtl/octave_value_noise_1d_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octave_value_noise_1d_unit
// One-dimensional fractal value noise over a loadable lattice table.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_stall is low and returns
// the noise value of each evaluate request; load requests travel the same
// pipeline, write every octave's private table copy when they reach the table
// stage and give no response. Each octave owns a lane with its own two-port
// copy of the lattice, so all octaves are sampled in the same cycle, and the
// final normalisation is a divider cut into eight stages. A stalled response
// freezes the whole pipeline. After reset and after every register write the
// unit holds req_stall while the octave weights are recomputed.
module octave_value_noise_1d_unit #(
   parameter int TABLE_DEPTH   = ovn_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_OCTAVES   = ovn_pkg::DEF_MAX_OCTAVES,
   parameter int FRACTION_BITS = ovn_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [ovn_pkg::COORD_W-1:0]  req_coordinate,
   input  logic [ovn_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [ovn_pkg::NOISE_W-1:0]         req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ovn_pkg::NOISE_W-1:0]         rsp_noise_value,
   input  logic                                csr_write,
   input  logic [ovn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ovn_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int WGT_W      = ovn_pkg::AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int TOT_W      = 2 * ovn_pkg::AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int GROUPS     = (MAX_OCTAVES + 3) / 4;
   localparam int LOAD_STAGE = 1 + ovn_pkg::RED_STAGES;
   localparam int LANE_OUT   = LOAD_STAGE + 2;
   localparam int LAST       = LANE_OUT + 3 + ovn_pkg::DIV_STAGES;
   localparam int N_STAGES   = LAST + 1;

   ovn_pkg::cfg_type          cfg;
   logic [ovn_pkg::AMP_W-1:0] amp [MAX_OCTAVES];
   logic [WGT_W-1:0]          weight;

   ovn_weights #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_weights (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .amp       (amp),
      .weight    (weight)
   );

   // request tags and load fields move with the data
   ovn_pkg::meta_type           meta_ff   [N_STAGES];
   logic [ovn_pkg::INDEX_W-1:0] ld_idx_ff [LOAD_STAGE+1];
   logic [ovn_pkg::NOISE_W-1:0] ld_val_ff [LOAD_STAGE+1];

   logic advance;
   logic accept;

   assign rsp_valid = meta_ff[LAST].valid && meta_ff[LAST].evaluate;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || cfg.busy;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N_STAGES; k++) begin
            meta_ff[k] <= '0;
         end
      end else if (advance) begin
         meta_ff[0].valid    <= accept;
         meta_ff[0].evaluate <= (req_action == ovn_pkg::ACTION_EVALUATE);
         for (int k = 1; k < N_STAGES; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ld_idx_ff[0] <= req_entry_index;
         ld_val_ff[0] <= req_entry_value;
         for (int k = 1; k <= LOAD_STAGE; k++) begin
            ld_idx_ff[k] <= ld_idx_ff[k-1];
            ld_val_ff[k] <= ld_val_ff[k-1];
         end
      end
   end

   logic wr_en;

   assign wr_en = advance && meta_ff[LOAD_STAGE].valid && !meta_ff[LOAD_STAGE].evaluate
                  && (32'(ld_idx_ff[LOAD_STAGE]) < TABLE_DEPTH);

   // scaled coordinate, then per octave position
   logic signed [56:0] scaled_ff;
   logic [63:0]        scaled_ext, offset_ext;
   logic [63:0]        pos_ff [MAX_OCTAVES];

   assign scaled_ext = {{7{scaled_ff[56]}}, scaled_ff};
   assign offset_ext = {{16{cfg.offset[31]}}, cfg.offset, 16'b0};

   always_ff @(posedge clock) begin
      if (advance) begin
         scaled_ff <= req_coordinate * $signed({1'b0, cfg.freq});
         for (int i = 0; i < MAX_OCTAVES; i++) begin
            pos_ff[i] <= (scaled_ext << i) + offset_ext;
         end
      end
   end

   logic [ovn_pkg::NOISE_W-1:0] lane_value [MAX_OCTAVES];

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
      ovn_lane #(
         .TABLE_DEPTH   (TABLE_DEPTH),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_lane (
         .clock   (clock),
         .advance (advance),
         .pos     (pos_ff[i]),
         .wr_en   (wr_en),
         .wr_addr (IDX_W'(ld_idx_ff[LOAD_STAGE])),
         .wr_data (ld_val_ff[LOAD_STAGE]),
         .value   (lane_value[i])
      );
   end

   // weighted sum, products then two adder levels
   logic [2*ovn_pkg::AMP_W-1:0] prod_ff  [MAX_OCTAVES];
   logic [TOT_W-1:0]            group_ff [GROUPS];
   logic [TOT_W-1:0]            group_in [GROUPS];
   logic [TOT_W-1:0]            total_ff, total_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < 4; k++) begin
            if (4 * g + k < MAX_OCTAVES) begin
               group_in[g] = group_in[g] + TOT_W'(prod_ff[4 * g + k]);
            end
         end
      end
      total_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total_in = total_in + group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < MAX_OCTAVES; i++) begin
            if (ovn_pkg::OCT_W'(i) < cfg.octaves) begin
               prod_ff[i] <= lane_value[i] * amp[i];
            end else begin
               prod_ff[i] <= '0;
            end
         end
         group_ff <= group_in;
         total_ff <= total_in;
      end
   end

   ovn_divider #(
      .TOT_W (TOT_W),
      .WGT_W (WGT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .total    (total_ff),
      .weight   (weight),
      .quotient (rsp_noise_value)
   );

`ifndef SYNTHESIS
   a_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(meta_ff[0]))
      else $error("pipeline moved while response stalled");

   a_write_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("request taken while weights settle");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for octave_value_noise_1d_unit. The lattice is filled
// first. A short table of directed requests follows, and then random load and
// evaluate requests run under a series of register settings. Each evaluate
// request without a fixed expected value in the directed table is predicted by
// an in-bench model of the octave sum. The expected value is compared with the response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LATENCY_WAIT = 40;
   localparam int WATCHDOG_MAX = 5000;
   localparam int SEGMENTS     = 10;
   localparam int SEG_ITEMS    = 28;
   localparam logic [ovn_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      ovn_pkg::action_type action;
      logic [31:0] coord;
      logic [7:0]  idx;
      logic [15:0] val;
      bit          known;
      logic [15:0] want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic signed [ovn_pkg::COORD_W-1:0] req_coordinate;
   logic [ovn_pkg::INDEX_W-1:0]        req_entry_index;
   logic [ovn_pkg::NOISE_W-1:0]        req_entry_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [ovn_pkg::NOISE_W-1:0]        rsp_noise_value;
   logic        csr_write;
   logic [ovn_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [ovn_pkg::CSR_DATA_W-1:0]     csr_wdata;

   // bench copy of the block state
   logic [15:0] lattice_copy [256];
   logic [3:0]  m_octaves;
   logic [16:0] m_persistence;
   logic [23:0] m_frequency;
   logic [15:0] m_amplitude;
   logic signed [31:0] m_offset;

   logic [15:0] noise_expected [$];
   row_type     directed_rows [$];
   int          send_idle;
   int          recv_idle;
   int          mismatches;
   int          responses;
   int          idle_cycles;

   octave_value_noise_1d_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned fade_of(longint unsigned t);
      longint unsigned t2, t3, t4, t5;
      longint s;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      t4 = (t3 * t) >> 16;
      t5 = (t4 * t) >> 16;
      s = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
      return longint'(s);
   endfunction

   function automatic logic [15:0] noise_for(logic signed [31:0] x);
      longint scaled, shifted_off;
      logic [63:0] pos;
      longint unsigned amp, total, weight, s, a, b, result;
      int n;
      n = (m_octaves == 0) ? 1 : (m_octaves > 8) ? 8 : int'(m_octaves);
      scaled = longint'(x) * longint'(m_frequency);
      shifted_off = longint'(m_offset) <<< 16;
      amp = m_amplitude;
      total = 0;
      weight = 0;
      for (int i = 0; i < n; i++) begin
         pos = (scaled << i) + shifted_off;
         s = fade_of(pos[31:16]);
         a = lattice_copy[pos[39:32]];
         b = lattice_copy[pos[39:32] + 8'd1];
         total += ((a * (65536 - s) + b * s) >> 16) * amp;
         weight += amp;
         amp = (amp * m_persistence) >> 16;
         if (amp > 65535) amp = 65535;
      end
      result = (weight != 0) ? total / weight : 0;
      if (result > 65535) result = 65535;
      return result[15:0];
   endfunction

   task automatic add_row(ovn_pkg::action_type act, logic [31:0] coord, logic [7:0] idx,
                          logic [15:0] val, bit known, logic [15:0] want);
      row_type r;
      r.action = act;
      r.coord  = coord;
      r.idx    = idx;
      r.val    = val;
      r.known  = known;
      r.want   = want;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   task automatic push_request(ovn_pkg::action_type act, logic [31:0] coord,
                               logic [7:0] idx, logic [15:0] val, bit known,
                               logic [15:0] want);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_coordinate  <= coord;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ovn_pkg::ACTION_LOAD) begin
         lattice_copy[idx] = val;
      end else begin
         noise_expected.insert(noise_expected.size(), known ? want : noise_for(coord));
      end
   endtask

   task automatic write_reg(logic [ovn_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         ovn_pkg::CSR_OCTAVE_COUNT:   m_octaves     = data[3:0];
         ovn_pkg::CSR_PERSISTENCE:    m_persistence = data[16:0];
         ovn_pkg::CSR_BASE_FREQUENCY: m_frequency   = data[23:0];
         ovn_pkg::CSR_BASE_AMPLITUDE: m_amplitude   = data[15:0];
         ovn_pkg::CSR_PHASE_OFFSET:   m_offset      = data;
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] oct, logic [31:0] pers, logic [31:0] freq,
                            logic [31:0] amp, logic [31:0] off);
      req_valid <= 1'b0;
      @(posedge clock);
      while (noise_expected.size() != 0) @(posedge clock);
      // trailing loads may still be in flight
      repeat (LATENCY_WAIT) @(posedge clock);
      write_reg(ovn_pkg::CSR_OCTAVE_COUNT, oct);
      write_reg(ovn_pkg::CSR_PERSISTENCE, pers);
      write_reg(ovn_pkg::CSR_BASE_FREQUENCY, freq);
      write_reg(ovn_pkg::CSR_BASE_AMPLITUDE, amp);
      write_reg(ovn_pkg::CSR_PHASE_OFFSET, off);
      write_reg(CSR_SPARE, $urandom);
      csr_write <= 1'b0;
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses <= responses + 1;
         if (noise_expected.size() == 0) begin
            if (mismatches < 10) $display("unexpected response %h", rsp_noise_value);
            mismatches <= mismatches + 1;
         end else begin
            if (rsp_noise_value !== noise_expected[0]) begin
               if (mismatches < 10) begin
                  $display("noise_value mismatch: expected %h, got %h",
                           noise_expected[0], rsp_noise_value);
               end
               mismatches <= mismatches + 1;
            end
            void'(noise_expected.pop_front());
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog expired, %0d responses outstanding", noise_expected.size());
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] coord;
      row_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ovn_pkg::ACTION_LOAD;
      req_coordinate = '0;
      req_entry_index = '0;
      req_entry_value = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      responses = 0;
      idle_cycles = 0;
      send_idle = 6;
      recv_idle = 68;
      m_octaves = ovn_pkg::RST_OCTAVE_COUNT;
      m_persistence = ovn_pkg::RST_PERSISTENCE;
      m_frequency = ovn_pkg::RST_BASE_FREQUENCY;
      m_amplitude = ovn_pkg::RST_BASE_AMPLITUDE;
      m_offset = ovn_pkg::RST_PHASE_OFFSET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every lattice word written before any evaluate, word i holds i*257
      for (int i = 0; i < 256; i++) begin
         push_request(ovn_pkg::ACTION_LOAD, '0, i[7:0], 16'(i * 257), 1'b0, '0);
      end

      // reset settings: an integer coordinate reads its lattice word directly
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h0000_0000, 8'h00, 16'h0000, 1, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h00FF_0000, 8'h00, 16'h0000, 1, 16'hFFFF);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'hFFFF_0000, 8'h00, 16'h0000, 1, 16'hFFFF);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h7FFF_0000, 8'h00, 16'h0000, 1, 16'hFFFF);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h8000_0000, 8'h00, 16'h0000, 1, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h0003_0000, 8'h00, 16'h0000, 1, 16'h0303);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h0000_8000, 8'h00, 16'h0000, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h7FFF_FFFF, 8'h00, 16'h0000, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'hFFFF_FFFF, 8'h00, 16'h0000, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h0010_0001, 8'h00, 16'h0000, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_LOAD,     32'hFFFF_FFFF, 8'h10, 16'hFFFF, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_LOAD,     32'h0000_0000, 8'hFF, 16'h0000, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h0010_0000, 8'h00, 16'h0000, 1, 16'hFFFF);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h00FF_0000, 8'h00, 16'h0000, 1, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h00FF_C000, 8'h00, 16'h0000, 0, 16'h0000);
      add_row(ovn_pkg::ACTION_EVALUATE, 32'h000F_4000, 8'h00, 16'h0000, 0, 16'h0000);
      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         push_request(r.action, r.coord, r.idx, r.val, r.known, r.want);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: configure(1, 32768, 65536, 256, 0);
            1: configure(8, 65536, 32'hFF_FFFF, 65535, 32'h7FFF_FFFF);
            2: configure(15, 131071, 1, 1, 32'h8000_0000);
            3: configure(0, 0, 65536, 0, 0);   // all weights zero
            4: configure(8, 1, 32'h12_3456, 1, $urandom);   // weights decay to zero
            default: configure($urandom_range(0, 15), $urandom_range(0, 131071),
                               $urandom & 32'hFF_FFFF, $urandom_range(0, 65535), $urandom);
         endcase
         if (seg == 4) begin
            send_idle = 68;
            recv_idle = 6;
         end else if (seg == 7) begin
            send_idle = 0;
            recv_idle = 0;
         end
         for (int k = 0; k < SEG_ITEMS; k++) begin
            if ($urandom_range(99) < 20) begin
               push_request(ovn_pkg::ACTION_LOAD, $urandom, 8'($urandom), 16'($urandom),
                            1'b0, '0);
            end else begin
               coord = ($urandom_range(1)) ? $urandom
                                           : $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
               push_request(ovn_pkg::ACTION_EVALUATE, coord, 8'($urandom), 16'($urandom),
                            1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
      $display("lattice fill, directed table and %0d random requests over %0d settings",
               SEGMENTS * SEG_ITEMS, SEGMENTS);
      $display("%0d responses checked, %0d mismatches", responses, mismatches);
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ovn_pkg.sv
rtl/ovn_lane.sv
rtl/ovn_weights.sv
rtl/ovn_divider.sv
rtl/octave_value_noise_1d_unit.sv
bench/tb_top.sv
